@@ design/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types, register indexes and constants of the spline sweep tessellator.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int unsigned MAX_STEPS  = 64;
  localparam int unsigned STEP_W     = $clog2(MAX_STEPS + 1);
  localparam int unsigned CNT_W      = $clog2(MAX_STEPS);
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned RAD_W      = 31;
  localparam int unsigned TQ_W       = 17;   // t in unsigned Q1.16, 65536 = 1.0
  localparam int unsigned WGT_W      = 34;   // basis weight, signed Q3.30 (+sign room)
  localparam int unsigned PROD_W     = 66;
  localparam int unsigned ACC_W      = 68;

  localparam logic [TQ_W-1:0] T_ONE  = TQ_W'(65536);

  typedef enum logic [1:0] {
    MODE_LINEAR  = 2'd0,
    MODE_BSPLINE = 2'd1,
    MODE_CATROM  = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_STEPS  = 2'd1,
    REG_TSTEP  = 2'd2,
    REG_UNUSED = 2'd3
  } reg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // shift accepted point into window
    logic clear;     // restart: zero window first
    logic samp;      // start one sample at index j
    logic fin;       // this sample is the final one
    logic [CNT_W-1:0] j;
  } sst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic busy;      // sample pipeline occupied
    logic out_full;  // output register holds an item
  } sst_sts_t;

endpackage

@@ design/sst_ctrl.sv @@
// ----------------------------------------------------------------------------
// sst_ctrl
// Sequencer: accepts points, tracks window fill, issues one sample per pass.
// ----------------------------------------------------------------------------
module sst_ctrl import sst_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              in_restart,
  input  logic [1:0]        mode,
  input  logic [6:0]        steps,
  input  sst_sts_t          sts,
  output logic              in_ready,
  output sst_cmd_t          cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ISSUE = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [2:0]        fill_r, fill_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [CNT_W-1:0]  last_j;
  logic [2:0]        fill_new;
  logic              emit;

  always_comb begin
    if (steps < 7'd2) last_j = CNT_W'(1);
    else if (steps > 7'(MAX_STEPS)) last_j = CNT_W'(MAX_STEPS - 1);
    else last_j = CNT_W'(steps - 7'd1);
  end

  always_comb begin
    fill_new = in_restart ? 3'd1 : ((fill_r < 3'd4) ? fill_r + 3'd1 : fill_r);
    unique case (mode)
      MODE_LINEAR:               emit = fill_new >= 3'd2;
      MODE_BSPLINE, MODE_CATROM: emit = fill_new >= 3'd4;
      default:                   emit = 1'b0;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    j_nxt     = j_r;
    cmd       = '0;
    cmd.j     = j_r;
    cmd.fin   = (j_r == last_j);
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          cmd.clear = in_restart;
          fill_nxt  = fill_new;
          j_nxt     = '0;
          if (emit) state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        // one sample in flight at a time; wait until the output slot drains
        if (!sts.busy && !sts.out_full) begin
          cmd.samp  = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!sts.busy) begin
          if (j_r == last_j) state_nxt = ST_IDLE;
          else begin
            j_nxt     = j_r + CNT_W'(1);
            state_nxt = ST_ISSUE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      j_r     <= j_nxt;
    end
  end

  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= 3'd4)
    else $error("fill count overflow");
  a_samp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.samp |-> !sts.busy && !sts.out_full)
    else $error("sample issued while datapath busy");
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("ready during segment");

endmodule

@@ design/sst_dp.sv @@
// ----------------------------------------------------------------------------
// sst_dp
// Window registers, basis weights, shared multiply-accumulate, output register.
// ----------------------------------------------------------------------------
module sst_dp import sst_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sst_cmd_t                  cmd,
  input  logic [1:0]                mode,
  input  logic [16:0]               t_step,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  input  logic signed [COORD_W-1:0] in_z,
  input  logic [RAD_W-1:0]          in_r,
  output sst_sts_t                  sts,
  output logic signed [COORD_W-1:0] o_x,
  output logic signed [COORD_W-1:0] o_y,
  output logic signed [COORD_W-1:0] o_z,
  output logic [RAD_W-1:0]          o_r,
  output logic                      o_last,
  output logic                      o_valid,
  input  logic                      o_ready
);

  // Window, entry 3 newest. Radius kept as signed 32 for common MAC.
  logic signed [COORD_W-1:0] win_r [4][4]; // [channel][entry]: x,y,z,r

  // Sample pipeline phases:
  //  p1: t = min(j*t_step, 1), or 1 on the final sample   p2: t^2   p3: t^3
  //  p4: weights (poly/divide or linear)  p5..p8: one MAC term per cycle, 4 channels
  logic [3:0]  ph_r;               // 0 = idle
  logic        fin_r;
  logic [CNT_W-1:0] j_r;
  logic [TQ_W-1:0]  t_r;
  logic [33:0]      t2_r;          // t^2, up to 2^32
  logic [50:0]      t3_r;          // t^3, up to 2^48
  logic signed [WGT_W-1:0] w_r  [4];
  logic signed [WGT_W-1:0] wr_r [4];
  logic signed [ACC_W-1:0] acc_r [4];
  logic [1:0]  k_r;

  logic [23:0] jt;
  always_comb jt = 24'(j_r) * 24'(t_step);

  // basis numerators, Q48 (signed, fits 54 bits)
  logic signed [55:0] t1q, t2q, t3q, one_q;
  logic signed [55:0] n0, n1, n2, n3;
  always_comb begin
    t1q   = 56'(t_r) <<< 32;
    t2q   = 56'(t2_r) <<< 16;
    t3q   = 56'(t3_r);
    one_q = 56'sd1 <<< 48;
    unique case (mode)
      MODE_BSPLINE: begin
        n0 = -t3q + 3*t2q - 3*t1q + one_q;
        n1 = 3*t3q - 6*t2q + 4*one_q;
        n2 = -3*t3q + 3*t2q + 3*t1q + one_q;
        n3 = t3q;
      end
      MODE_CATROM: begin
        n0 = -t3q + 2*t2q - t1q;
        n1 = 3*t3q - 5*t2q + 2*one_q;
        n2 = -3*t3q + 4*t2q + t1q;
        n3 = t3q - t2q;
      end
      default: begin
        n0 = '0; n1 = '0; n2 = '0; n3 = '0;
      end
    endcase
  end

  // round-half-up divide by 2^18 * (6 or 2); arithmetic shift floors
  function automatic logic signed [WGT_W-1:0] rdiv_w(input logic signed [55:0] n,
                                                     input logic six);
    logic signed [55:0] a, q;
    logic signed [55:0] hi;
    logic signed [89:0] m;
    begin
      if (six) begin
        a  = n + (56'sd3 <<< 18);
        hi = a >>> 19;                 // floor(a / 2^19)
        // floor(hi / 3): multiply by reciprocal, then fix
        m  = 90'(hi) * 90'sd715827883; // ~2^31/3
        q  = 56'(m >>> 31);
        if (hi - q*3 < 0)      q = q - 1;
        else if (hi - q*3 >= 3) q = q + 1;
        rdiv_w = WGT_W'(q);
      end else begin
        a = n + (56'sd1 <<< 18);
        rdiv_w = WGT_W'(a >>> 19);
      end
    end
  endfunction

  logic signed [COORD_W-1:0] tv;
  logic signed [WGT_W-1:0]   wv;
  logic signed [PROD_W-1:0]  prod [4];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (c == 3) begin
        if (mode == MODE_LINEAR) tv = (k_r == 2'd1) ? win_r[3][2] :
                                      (k_r == 2'd2) ? win_r[3][3] : '0;
        else tv = (k_r == 2'd1) ? win_r[3][1] : (k_r == 2'd2) ? win_r[3][2] : '0;
        wv = wr_r[k_r];
      end else begin
        tv = win_r[c][k_r];
        wv = w_r[k_r];
      end
      prod[c] = PROD_W'(tv) * PROD_W'(wv);
    end
  end

  function automatic logic signed [ACC_W-1:0] rnd30(input logic signed [ACC_W-1:0] s);
    begin
      rnd30 = (s + ($signed(ACC_W'(1)) <<< 29)) >>> 30;
    end
  endfunction

  logic signed [ACC_W-1:0] fr [4];
  always_comb for (int c = 0; c < 4; c++) fr[c] = rnd30(acc_r[c]);

  localparam logic signed [ACC_W-1:0] CMAX = ACC_W'(64'sh7FFFFFFF);
  localparam logic signed [ACC_W-1:0] CMIN = -CMAX - 1;

  assign sts.busy     = (ph_r != 4'd0);
  assign sts.out_full = o_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 4; c++)
        for (int e = 0; e < 4; e++)
          win_r[c][e] <= '0;
    end else if (cmd.load) begin
      for (int c = 0; c < 4; c++)
        for (int e = 0; e < 3; e++)
          win_r[c][e] <= cmd.clear ? '0 : win_r[c][e+1];
      win_r[0][3] <= in_x;
      win_r[1][3] <= in_y;
      win_r[2][3] <= in_z;
      win_r[3][3] <= {1'b0, in_r};
    end
    if (cmd.samp) begin
      j_r   <= cmd.j;
      fin_r <= cmd.fin;
    end
    unique case (ph_r)
      4'd1: t_r  <= (fin_r || jt >= 24'd65536) ? T_ONE : TQ_W'(jt);
      4'd2: t2_r <= 34'(t_r) * 34'(t_r);
      4'd3: t3_r <= 51'(t2_r) * 51'(t_r);
      4'd4: begin
        if (mode == MODE_LINEAR) begin
          w_r[0] <= '0; w_r[1] <= '0;
          w_r[2] <= WGT_W'(T_ONE - t_r) <<< 14;
          w_r[3] <= WGT_W'(t_r) <<< 14;
        end else begin
          w_r[0] <= rdiv_w(n0, mode == MODE_BSPLINE);
          w_r[1] <= rdiv_w(n1, mode == MODE_BSPLINE);
          w_r[2] <= rdiv_w(n2, mode == MODE_BSPLINE);
          w_r[3] <= rdiv_w(n3, mode == MODE_BSPLINE);
        end
        wr_r[0] <= '0;
        wr_r[1] <= WGT_W'(T_ONE - t_r) <<< 14;
        wr_r[2] <= WGT_W'(t_r) <<< 14;
        wr_r[3] <= '0;
        k_r <= 2'd0;
        for (int c = 0; c < 4; c++) acc_r[c] <= '0;
      end
      4'd5, 4'd6, 4'd7, 4'd8: begin
        for (int c = 0; c < 4; c++) acc_r[c] <= acc_r[c] + ACC_W'(prod[c]);
        k_r <= k_r + 2'd1;
      end
      4'd9: begin
        o_x <= (fr[0] > CMAX) ? COORD_W'(CMAX) : (fr[0] < CMIN) ? COORD_W'(CMIN)
                                                              : COORD_W'(fr[0]);
        o_y <= (fr[1] > CMAX) ? COORD_W'(CMAX) : (fr[1] < CMIN) ? COORD_W'(CMIN)
                                                              : COORD_W'(fr[1]);
        o_z <= (fr[2] > CMAX) ? COORD_W'(CMAX) : (fr[2] < CMIN) ? COORD_W'(CMIN)
                                                              : COORD_W'(fr[2]);
        o_r <= (fr[3] > CMAX) ? RAD_W'(CMAX) : (fr[3] < 0) ? '0 : RAD_W'(fr[3]);
        o_last <= fin_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= '0;
      o_valid <= 1'b0;
    end else begin
      if (cmd.samp) ph_r <= 4'd1;
      else if (ph_r == 4'd9) ph_r <= 4'd0;
      else if (ph_r != 4'd0) ph_r <= ph_r + 4'd1;
      if (ph_r == 4'd9) o_valid <= 1'b1;
      else if (o_ready) o_valid <= 1'b0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == 4'd9) |-> !o_valid || o_ready)
    else $error("output overwritten");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> ph_r == 4'd0)
    else $error("window shifted mid-sample");
  a_ph_range: assert property (@(posedge clk) disable iff (!rst_n) ph_r <= 4'd9)
    else $error("phase out of range");

endmodule

@@ design/spline_sweep_tessellator_core.sv @@
// ----------------------------------------------------------------------------
// spline_sweep_tessellator_core
// Sweeps control spheres into linear, B-spline or Catmull-Rom sample runs.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_       in   tvalid/tready      tdata {radius,z,y,x}, tuser restart
//  out_      out  tvalid/tready      tdata {pr,pz,py,px}, tlast last
//  cfg_      in   wr_en              index 0 mode, 1 steps, 2 t_step
//
// A point is taken while the sequencer is idle; each of its samples then runs
// through issue, t, t^2, t^3, weights, four shared multiply-accumulate passes,
// output and hand-back, one sample at a time. Input is held off while a
// segment is in progress. Output stalls freeze the sequencer before the next
// sample. Reset is synchronous, active low.
module spline_sweep_tessellator_core import sst_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [127:0]  in_tdata,   // x[31:0], y[63:32], z[95:64], radius[126:96]
  input  logic          in_tuser,   // restart
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,  // px[31:0], py[63:32], pz[95:64], pr[126:96]
  output logic          out_tlast,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_index,
  input  logic [16:0]   cfg_data
);

  logic [1:0]  mode_r;
  logic [6:0]  steps_r;
  logic [16:0] tstep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_LINEAR;
      steps_r <= 7'd16;
      tstep_r <= 17'd4369;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODE:  mode_r  <= cfg_data[1:0];
        REG_STEPS: steps_r <= cfg_data[6:0];
        REG_TSTEP: tstep_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sst_cmd_t cmd;
  sst_sts_t sts;
  logic     in_fire;
  logic signed [COORD_W-1:0] ox, oy, oz;
  logic [RAD_W-1:0]          orr;

  assign in_fire = in_tvalid && in_tready;

  sst_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_restart(in_tuser), .mode(mode_r),
    .steps(steps_r), .sts, .in_ready(in_tready), .cmd
  );

  sst_dp u_dp (
    .clk, .rst_n, .cmd, .mode(mode_r), .t_step(tstep_r),
    .in_x(in_tdata[31:0]), .in_y(in_tdata[63:32]), .in_z(in_tdata[95:64]),
    .in_r(in_tdata[126:96]), .sts,
    .o_x(ox), .o_y(oy), .o_z(oz), .o_r(orr), .o_last(out_tlast),
    .o_valid(out_tvalid), .o_ready(out_tready)
  );

  assign out_tdata = {1'b0, orr, oz, oy, ox};

endmodule
